// File: rtl/assert_macros.svh
// assertion macros shared by the rtl of the stepper speed and phase controller
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, expr, msg)

`define ASSERT_IMPLY(lbl, ante, cons, msg)

`endif

`endif

// File: rtl/ssp_pkg.sv
// types, constants and lookup tables of the stepper speed and phase controller
// no dependencies
package ssp_pkg;

  localparam int NUM_SPEEDS = 10;
  localparam int NUM_PHASES = 8;

  localparam int SPD_W = 6;
  localparam int SUM_W = SPD_W + 1;
  localparam int MAG_W = 5;
  localparam int PER_W = 8;
  localparam int PH_W  = 3;
  localparam int DRV_W = 4;
  localparam int OUT_SPD_W = 5;

  localparam logic signed [SUM_W-1:0] SPD_MAX = SUM_W'(NUM_SPEEDS);
  localparam logic signed [SUM_W-1:0] SPD_MIN = -SUM_W'(NUM_SPEEDS);
  localparam logic [PH_W-1:0] PH_LAST = PH_W'(NUM_PHASES - 1);

  localparam logic [PER_W-1:0] PERIOD_LUT [16] = '{
    8'd250, 8'd125, 8'd84, 8'd62, 8'd50, 8'd41, 8'd35, 8'd41,
    8'd28, 8'd25, 8'd25, 8'd25, 8'd25, 8'd25, 8'd25, 8'd25
  };

  localparam logic [DRV_W-1:0] PHASE_LUT [8] = '{
    4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hc, 4'h8, 4'h9
  };

  typedef struct packed {
    logic signed [SPD_W-1:0] speed;
    logic [PER_W-1:0]        period;
    logic [PER_W-1:0]        count;
    logic [PH_W-1:0]         phase;
    logic [DRV_W-1:0]        drive;
  } ssp_state_t;

  localparam ssp_state_t RESET_STATE = '{
    speed:  '0,
    period: PERIOD_LUT[0],
    count:  '0,
    phase:  '0,
    drive:  '0
  };

endpackage

// File: rtl/stepper_speed_phase_controller.sv
// Half-step stepper speed and phase controller. Each input word is a timer tick
// (func 0) or a signed speed change (func 1); every word yields one result word
// with the latched coil pattern, a step flag and the speed after that word.
// Speed saturates at +/-10 and picks the step period from a fixed table; a tick
// at nonzero speed counts up and, on reaching the period, latches the next
// half-step pattern. Throughput is one word per clock while out_stall is low: a
// word is held in the input register, the state update is a single combinational
// pass, and its result is then loaded into the result register.
// Depends on ssp_pkg, ssp_step and assert_macros.svh.
`include "assert_macros.svh"

module stepper_speed_phase_controller (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_func,
  input  logic signed [5:0] in_delta,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [3:0]        out_drive,
  output logic              out_stepped,
  output logic signed [4:0] out_speed
);
  import ssp_pkg::*;

  logic                   s1_valid_r;
  logic                   s1_func_r;
  logic signed [5:0]      s1_delta_r;
  ssp_state_t             state_r;
  ssp_state_t             state_nxt;
  logic                   stepped_nxt;
  logic                   out_valid_r;
  logic [DRV_W-1:0]       out_drive_r;
  logic                   out_stepped_r;
  logic signed [OUT_SPD_W-1:0] out_speed_r;
  logic                   out_free;
  logic                   s1_adv;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;

  ssp_step u_step (
    .func    (s1_func_r),
    .delta   (s1_delta_r),
    .cur     (state_r),
    .nxt     (state_nxt),
    .stepped (stepped_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_func_r  <= in_func;
      s1_delta_r <= in_delta;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= RESET_STATE;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        state_r <= state_nxt;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_drive_r   <= state_nxt.drive;
      out_stepped_r <= stepped_nxt;
      out_speed_r   <= state_nxt.speed[OUT_SPD_W-1:0];
    end
  end

  assign out_valid   = out_valid_r;
  assign out_drive   = out_drive_r;
  assign out_stepped = out_stepped_r;
  assign out_speed   = out_speed_r;

  // state stays within its legal ranges
  `ASSERT_ALWAYS(a_speed_range, (state_r.speed <= SPD_MAX) && (state_r.speed >= SPD_MIN), "speed out of range")
  `ASSERT_ALWAYS(a_phase_range, state_r.phase <= PH_LAST, "phase index out of range")
  // a step is only reported while the motor is turning
  `ASSERT_IMPLY(a_step_speed, out_valid_r && out_stepped_r, out_speed_r != '0, "step at zero speed")

endmodule

// File: rtl/ssp_step.sv
// next-state logic for one word: speed adjustment or timer tick
// depends on ssp_pkg
module ssp_step (
  input  logic                    func,
  input  logic signed [5:0]       delta,
  input  ssp_pkg::ssp_state_t     cur,
  output ssp_pkg::ssp_state_t     nxt,
  output logic                    stepped
);
  import ssp_pkg::*;

  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] sat;
  logic signed [SUM_W-1:0] neg;
  logic [MAG_W-1:0]        mag;
  logic [PER_W-1:0]        cnt_inc;

  always_comb begin
    nxt     = cur;
    stepped = 1'b0;
    sum     = {cur.speed[SPD_W-1], cur.speed} + {delta[5], delta};
    if (sum > SPD_MAX) begin
      sat = SPD_MAX;
    end else if (sum < SPD_MIN) begin
      sat = SPD_MIN;
    end else begin
      sat = sum;
    end
    neg     = -sat;
    mag     = sat[SUM_W-1] ? neg[MAG_W-1:0] : sat[MAG_W-1:0];
    cnt_inc = cur.count + 8'd1;
    if (func) begin
      nxt.speed = sat[SPD_W-1:0];
      if (mag == '0) begin
        nxt.period = '0;
      end else begin
        nxt.period = PERIOD_LUT[4'(mag - 5'd1)];
      end
    end else if (cur.speed != '0) begin
      nxt.count = cnt_inc;
      if (cnt_inc >= cur.period) begin
        nxt.drive = PHASE_LUT[cur.phase];
        nxt.count = '0;
        stepped   = 1'b1;
        if (!cur.speed[SPD_W-1]) begin
          nxt.phase = (cur.phase == PH_LAST) ? '0 : cur.phase + 3'd1;
        end else begin
          nxt.phase = (cur.phase == '0) ? PH_LAST : cur.phase - 3'd1;
        end
      end
    end
  end

endmodule
